@@ rtl/bbp_pkg.sv @@
// Shared types and constants for the bounding box pick block.
// Used by the channel interfaces, the register file, the controller and the datapath.
package bbp_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned IdxW   = 8;
  localparam int unsigned ScrW   = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned CountW = 9;
  localparam int unsigned LayPosW  = 12;
  localparam int unsigned LayDimW  = 13;

  localparam int unsigned MaxShapesDef = 256;

  // Configuration port.
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = $clog2(NumRegs);
  localparam int unsigned PAddrW   = RegIdxW + 2;
  localparam int unsigned PDataW   = 32;
  localparam logic [CoordW-1:0] ScaleReset = 32'h0001_0000;

  typedef enum logic [RegIdxW-1:0] {
    REG_LAYER_X      = 3'd0,
    REG_LAYER_Y      = 3'd1,
    REG_LAYER_WIDTH  = 3'd2,
    REG_LAYER_HEIGHT = 3'd3,
    REG_TRANS_X      = 3'd4,
    REG_TRANS_Y      = 3'd5,
    REG_SCALE        = 3'd6,
    REG_SHAPE_COUNT  = 3'd7
  } reg_idx_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } command_e;

  typedef struct packed {
    logic [LayPosW-1:0]       layer_x;
    logic [LayPosW-1:0]       layer_y;
    logic [LayDimW-1:0]       layer_width;
    logic [LayDimW-1:0]       layer_height;
    logic signed [CoordW-1:0] trans_x;
    logic signed [CoordW-1:0] trans_y;
    logic [CoordW-1:0]        scale;
    logic [CountW-1:0]        shape_count;
  } cfg_t;

  // One stored box.
  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] bottom;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // write the input beat into the box table
    logic start;  // latch the query point and clear the hit
    logic issue;  // read the next table entry
    logic emit;   // move the hit into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic run_ok;     // point inside the layer and table not empty
    logic last_addr;  // entry being read is the last valid one
    logic pipe_busy;  // compare pipeline still holds entries
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

@@ rtl/bbp_if.sv @@
// Valid/ready channel interfaces for input and result beats.
// Depends on bbp_pkg for the field widths.
interface bbp_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     command;
  logic [bbp_pkg::IdxW-1:0]                 entry_index;
  logic signed [bbp_pkg::ScrW-1:0]          point_x;
  logic signed [bbp_pkg::ScrW-1:0]          point_y;
  logic signed [bbp_pkg::CoordW-1:0]        box_min_x;
  logic signed [bbp_pkg::CoordW-1:0]        box_min_y;
  logic signed [bbp_pkg::CoordW-1:0]        box_max_x;
  logic signed [bbp_pkg::CoordW-1:0]        box_max_y;

  modport source (
    output valid, command, entry_index, point_x, point_y,
           box_min_x, box_min_y, box_max_x, box_max_y,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, point_x, point_y,
           box_min_x, box_min_y, box_max_x, box_max_y,
    output ready
  );
endinterface

interface bbp_out_if;
  logic                     valid;
  logic                     ready;
  logic                     hit_found;
  logic [bbp_pkg::IdxW-1:0] hit_index;

  modport source (output valid, hit_found, hit_index, input ready);
  modport sink (input valid, hit_found, hit_index, output ready);
endinterface

@@ rtl/bbp_regs.sv @@
// APB-style configuration register file for the bounding box pick block.
// Depends on bbp_pkg for the register map and the configuration struct.
module bbp_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbp_pkg::PAddrW-1:0]    paddr,
  input  logic [bbp_pkg::PDataW-1:0]    pwdata,
  output logic [bbp_pkg::PDataW-1:0]    prdata,
  output logic                          pready,
  output bbp_pkg::cfg_t                 cfg_o
);

  bbp_pkg::cfg_t    cfg_q;
  bbp_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = bbp_pkg::reg_idx_e'(paddr[bbp_pkg::PAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      cfg_q.scale <= bbp_pkg::ScaleReset;
    end else if (wr_en) begin
      unique case (idx)
        bbp_pkg::REG_LAYER_X:      cfg_q.layer_x      <= pwdata[bbp_pkg::LayPosW-1:0];
        bbp_pkg::REG_LAYER_Y:      cfg_q.layer_y      <= pwdata[bbp_pkg::LayPosW-1:0];
        bbp_pkg::REG_LAYER_WIDTH:  cfg_q.layer_width  <= pwdata[bbp_pkg::LayDimW-1:0];
        bbp_pkg::REG_LAYER_HEIGHT: cfg_q.layer_height <= pwdata[bbp_pkg::LayDimW-1:0];
        bbp_pkg::REG_TRANS_X:      cfg_q.trans_x      <= $signed(pwdata);
        bbp_pkg::REG_TRANS_Y:      cfg_q.trans_y      <= $signed(pwdata);
        bbp_pkg::REG_SCALE:        cfg_q.scale        <= pwdata;
        bbp_pkg::REG_SHAPE_COUNT:  cfg_q.shape_count  <= pwdata[bbp_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bbp_pkg::REG_LAYER_X:      prdata = bbp_pkg::PDataW'(cfg_q.layer_x);
      bbp_pkg::REG_LAYER_Y:      prdata = bbp_pkg::PDataW'(cfg_q.layer_y);
      bbp_pkg::REG_LAYER_WIDTH:  prdata = bbp_pkg::PDataW'(cfg_q.layer_width);
      bbp_pkg::REG_LAYER_HEIGHT: prdata = bbp_pkg::PDataW'(cfg_q.layer_height);
      bbp_pkg::REG_TRANS_X:      prdata = unsigned'(cfg_q.trans_x);
      bbp_pkg::REG_TRANS_Y:      prdata = unsigned'(cfg_q.trans_y);
      bbp_pkg::REG_SCALE:        prdata = cfg_q.scale;
      bbp_pkg::REG_SHAPE_COUNT:  prdata = bbp_pkg::PDataW'(cfg_q.shape_count);
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ rtl/bbp_ctrl.sv @@
// Sequencer for the bounding box pick block: loads, query setup, table scan and result hand-off.
// Depends on bbp_pkg for the command and status structs.
module bbp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_command_i,
  output logic          in_ready_o,
  input  bbp_pkg::sts_t sts_i,
  output bbp_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q, rdy_d;
  logic   accept;

  assign accept     = in_valid_i && rdy_q;
  assign in_ready_o = rdy_q;

  always_comb begin
    state_d = state_q;
    rdy_d   = rdy_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_command_i == bbp_pkg::CMD_QUERY) begin
            cmd_o.start = 1'b1;
            rdy_d       = 1'b0;
            state_d     = S_CHECK;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_CHECK: begin
        state_d = sts_i.run_ok ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_addr) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          rdy_d      = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_q == S_IDLE && !cmd_o.start) ? 1'b1 : rdy_d;
    end
  end

endmodule

@@ rtl/bbp_dp.sv @@
// Datapath of the bounding box pick block: box table, point offset, scaled bound
// compare pipeline, hit tracking and output register. Depends on bbp_pkg and bbp_if.
module bbp_dp #(
  parameter int unsigned MAX_SHAPES = bbp_pkg::MaxShapesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bbp_pkg::cfg_t  cfg_i,
  input  bbp_pkg::cmd_t  cmd_i,
  output bbp_pkg::sts_t  sts_o,
  bbp_in_if.sink         in_i,
  bbp_out_if.source      out_o
);

  localparam int unsigned AddrW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int unsigned CntW  = ($clog2(MAX_SHAPES + 1) > bbp_pkg::CountW) ?
                                  $clog2(MAX_SHAPES + 1) : bbp_pkg::CountW;
  localparam int unsigned CW    = bbp_pkg::CoordW;
  localparam int unsigned DW    = CW + 2;       // offset point, Q18.16
  localparam int unsigned PW    = 2 * CW;       // Q32.32 compare width

  // Box table, one row per shape.
  bbp_pkg::entry_t mem_q [MAX_SHAPES];
  bbp_pkg::entry_t rd_q;

  logic [AddrW-1:0] addr_q, idx1_q, idx2_q, hit_q;
  logic [CntW-1:0]  cnt_q, cnt_d, sc;
  logic             v1_q, v2_q, found_q, inside_q;
  logic signed [DW-1:0] dx_q, dy_q, dx_d, dy_d;
  logic signed [PW-1:0] pl_q, pt_q, pr_q, pb_q;
  logic signed [PW:0]   pl, pt, pr, pb;
  logic signed [CW:0]   scl;
  logic signed [PW-1:0] dsx, dsy;
  logic             match;

  logic             out_valid_q, out_found_q;
  logic [bbp_pkg::IdxW-1:0] out_index_q;

  // Layer test and offset point.
  logic signed [bbp_pkg::ScrW+1:0] sx, sy, lx, ly, lxe, lye, rx, ry;
  logic inside_d;

  always_comb begin
    sx  = $signed({{2{in_i.point_x[bbp_pkg::ScrW-1]}}, in_i.point_x});
    sy  = $signed({{2{in_i.point_y[bbp_pkg::ScrW-1]}}, in_i.point_y});
    lx  = $signed({6'b0, cfg_i.layer_x});
    ly  = $signed({6'b0, cfg_i.layer_y});
    lxe = lx + $signed({5'b0, cfg_i.layer_width});
    lye = ly + $signed({5'b0, cfg_i.layer_height});
    inside_d = (sx >= lx) && (sx < lxe) && (sy >= ly) && (sy < lye);
    rx  = sx - lx;
    ry  = sy - ly;
    // only used when inside the layer, so the offset is 0..8190
    dx_d = $signed({5'b0, rx[12:0], 16'h0}) -
           $signed({{2{cfg_i.trans_x[CW-1]}}, cfg_i.trans_x});
    dy_d = $signed({5'b0, ry[12:0], 16'h0}) -
           $signed({{2{cfg_i.trans_y[CW-1]}}, cfg_i.trans_y});
    sc    = CntW'(cfg_i.shape_count);
    cnt_d = (sc > CntW'(MAX_SHAPES)) ? CntW'(MAX_SHAPES) : sc;
  end

  // Table write and read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (CntW'(in_i.entry_index) < CntW'(MAX_SHAPES))) begin
      mem_q[AddrW'(in_i.entry_index)] <= '{left:   in_i.box_min_x,
                                            top:    in_i.box_min_y,
                                            right:  in_i.box_max_x,
                                            bottom: in_i.box_max_y};
    end
    if (cmd_i.issue) begin
      rd_q <= mem_q[addr_q];
    end
  end

  // Scale each bound: signed 32 x unsigned 32.
  always_comb begin
    scl = $signed({1'b0, cfg_i.scale});
    pl  = rd_q.left   * scl;
    pt  = rd_q.top    * scl;
    pr  = rd_q.right  * scl;
    pb  = rd_q.bottom * scl;
    dsx = $signed({dx_q, 16'h0});
    dsy = $signed({dy_q, 16'h0});
    match = (dsx >= pl_q) && (dsx <= pr_q) && (dsy >= pt_q) && (dsy <= pb_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      cnt_q <= cnt_d;
    end
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    pl_q   <= pl[PW-1:0];
    pt_q   <= pt[PW-1:0];
    pr_q   <= pr[PW-1:0];
    pb_q   <= pb[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      found_q  <= 1'b0;
      hit_q    <= '0;
      inside_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        addr_q   <= '0;
        found_q  <= 1'b0;
        hit_q    <= '0;
        inside_q <= inside_d;
      end else begin
        if (cmd_i.issue) begin
          addr_q <= addr_q + AddrW'(1);
        end
        // ascending scan: the last match is the highest index
        if (v2_q && match) begin
          found_q <= 1'b1;
          hit_q   <= idx2_q;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_found_q <= found_q;
      out_index_q <= bbp_pkg::IdxW'(hit_q);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hit_found = out_found_q;
  assign out_o.hit_index = out_index_q;

  assign sts_o.run_ok    = inside_q && (cnt_q != '0);
  assign sts_o.last_addr = (CntW'(addr_q) + CntW'(1)) == cnt_q;
  assign sts_o.pipe_busy = v1_q || v2_q;
  assign sts_o.out_free  = !out_valid_q || out_o.ready;

endmodule

@@ rtl/bounding_box_pick.sv @@
// Top level of the bounding box pick block: APB registers, sequencer and datapath.
// Depends on bbp_pkg, bbp_if, bbp_regs, bbp_ctrl and bbp_dp.
//
// Use: beats on in_i either load one box into table slot entry_index (command 0)
// or query a screen point (command 1). A load gives no result.
// A query gives one beat on out_o: hit_found and the highest index of a box that
// holds the point, 0 when none. With N = min(shape_count, MAX_SHAPES), a query
// whose point lies in the layer runs a layer check, then reads the N table
// entries one entry per cycle through a single read port, then drains the
// scale-and-compare pipeline and moves the hit into the output register. A point
// outside the layer, or an empty table, skips the scan and goes from the layer
// check straight to the output register.
// One item is worked on at a time; in_i.ready drops while a query runs and rises
// again once its result sits in the output register.
// If out_o stalls, the result waits there and the block still takes the next
// item, but a second finished query waits until the first one is taken.
// Reset clears the control state and the registers (scale to 1.0); the box table
// holds garbage until loaded. Write the registers only while the block is idle.
module bounding_box_pick #(
  parameter int unsigned MAX_SHAPES = bbp_pkg::MaxShapesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbp_pkg::PAddrW-1:0] paddr,
  input  logic [bbp_pkg::PDataW-1:0] pwdata,
  output logic [bbp_pkg::PDataW-1:0] prdata,
  output logic                       pready,
  bbp_in_if.sink                     in_i,
  bbp_out_if.source                  out_o
);

  bbp_pkg::cfg_t cfg;
  bbp_pkg::cmd_t cmd;
  bbp_pkg::sts_t sts;
  logic          in_ready;

  assign in_i.ready = in_ready;

  bbp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bbp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  bbp_dp #(
    .MAX_SHAPES (MAX_SHAPES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o)
  );

`ifndef SYNTH
  // a result never overwrites one that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_o.valid || out_o.ready))
    else $error("result emitted into a full output register");

  // no beat is taken while the table is being scanned
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !in_i.ready)
    else $error("input ready during table scan");

  // an accepted query closes the input until its result is out
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.command == bbp_pkg::CMD_QUERY) |=> !in_i.ready)
    else $error("input ready right after a query");

  // a result is never emitted while the compare pipeline is busy or the table is read
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !sts.pipe_busy && !cmd.issue)
    else $error("result emitted while compare pipeline busy");
`endif

endmodule
